// ----- design/vbr_pkg.sv -----
// Package for valence_bond_reconnect: item structs, pair table types, widths,
// command codes and the ring-size divisor mask function.
// No dependencies.
package vbr_pkg;

  localparam int MaxSites  = 32;
  localparam int PairSlots = MaxSites / 2;
  localparam int SiteW     = $clog2(MaxSites);
  localparam int SlotW     = $clog2(PairSlots);
  localparam int UsedW     = $clog2(PairSlots + 1);
  localparam int RingW     = 6;
  localparam int CntW      = $clog2(PairSlots + 1);
  // Nonnegative differences between two sites plus or minus one stay within 0..MaxSites.
  localparam int MaskW     = MaxSites + 1;
  localparam int MaskIdxW  = $clog2(MaskW);
  localparam int DiffW     = SiteW + 2;

  localparam logic [RingW-1:0] RingReset = RingW'(30);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_APPLY = 1'b1;

  typedef logic [SiteW-1:0] site_t;

  typedef struct packed {
    site_t b;
    site_t a;
  } pair_t;

  typedef pair_t [PairSlots-1:0] pair_tab_t;

  typedef struct packed {
    logic             cmd;
    logic [SlotW-1:0] slot;
    site_t            site_a;
    site_t            site_b;
  } in_item_t;

  typedef struct packed {
    logic            reconnected;
    logic [CntW-1:0] neighbour_bonds;
  } out_item_t;

  // Bit d set when d is a multiple of ring (d = 0..MaxSites); all zero for ring 0.
  function automatic logic [MaskW-1:0] mult_mask(input logic [RingW-1:0] ring);
    logic [MaskW-1:0] m;
    m = '0;
    for (int k = 1; k < (1 << RingW); k++) begin
      if (ring == RingW'(k)) begin
        for (int d = 0; d < MaskW; d += k) begin
          m[d] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  localparam logic [MaskW-1:0] MaskReset = mult_mask(RingReset);

endpackage

// ----- design/vbr_table.sv -----
// Pair table cells with parallel site match, reconnect swap and load write.
// Depends on vbr_pkg.
module vbr_table import vbr_pkg::*; (
  input  logic             clk_i,
  input  logic             fire_i,
  input  in_item_t         item_i,
  input  logic [UsedW-1:0] used_i,
  output pair_tab_t        tab_nxt_o,
  output logic             reconnected_o
);

  pair_tab_t        tab_q;
  pair_tab_t        tab_d;
  logic             fa, fb, p0, p1, swap;
  logic [SlotW-1:0] s0, s1;
  site_t            partner;

  always_comb begin
    fa      = 1'b0;
    fb      = 1'b0;
    p0      = 1'b0;
    p1      = 1'b0;
    s0      = '0;
    s1      = '0;
    partner = '0;
    for (int i = 0; i < PairSlots; i++) begin
      if (used_i > UsedW'(i)) begin
        if (tab_q[i].a == item_i.site_a) begin
          fa = 1'b1; s0 = SlotW'(i); p0 = 1'b0; partner = tab_q[i].b;
        end
        if (tab_q[i].b == item_i.site_a) begin
          fa = 1'b1; s0 = SlotW'(i); p0 = 1'b1; partner = tab_q[i].a;
        end
        if (tab_q[i].a == item_i.site_b) begin
          fb = 1'b1; s1 = SlotW'(i); p1 = 1'b0;
        end
        if (tab_q[i].b == item_i.site_b) begin
          fb = 1'b1; s1 = SlotW'(i); p1 = 1'b1;
        end
      end
    end
    swap = (item_i.cmd == CMD_APPLY) && fa && fb && (s0 != s1);
  end

  always_comb begin
    for (int i = 0; i < PairSlots; i++) begin
      tab_d[i] = tab_q[i];
      if ((item_i.cmd == CMD_LOAD) && (item_i.slot == SlotW'(i))) begin
        tab_d[i].a = item_i.site_a;
        tab_d[i].b = item_i.site_b;
      end else if (swap) begin
        if (s1 == SlotW'(i)) begin
          if (p1) begin
            tab_d[i].b = partner;
          end else begin
            tab_d[i].a = partner;
          end
        end
        // first site's old partner slot gets the second site
        if (s0 == SlotW'(i)) begin
          if (p0) begin
            tab_d[i].a = item_i.site_b;
          end else begin
            tab_d[i].b = item_i.site_b;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      tab_q <= tab_d;
    end
  end

  assign tab_nxt_o     = tab_d;
  assign reconnected_o = swap;

endmodule

// ----- design/vbr_nbr_count.sv -----
// Counts used pairs whose two sites are neighbours on the ring.
// Depends on vbr_pkg; takes the divisor mask of the current ring size.
module vbr_nbr_count import vbr_pkg::*; (
  input  pair_tab_t        tab_i,
  input  logic [UsedW-1:0] used_i,
  input  logic [RingW-1:0] ring_i,
  input  logic [MaskW-1:0] mask_i,
  output logic [CntW-1:0]  count_o
);

  logic [PairSlots-1:0] nb;

  always_comb begin
    for (int i = 0; i < PairSlots; i++) begin
      logic [DiffW-1:0] da, db, dc;
      logic             in_ring, hit_a, hit_b;
      // x == (y+1) mod r   <=> x < r and y+1-x a nonnegative multiple of r
      // x == (y+r-1) mod r <=> x < r and y-1-x a nonnegative multiple of r, or x-y+1 == r
      da      = DiffW'(tab_i[i].b) + DiffW'(1) - DiffW'(tab_i[i].a);
      db      = DiffW'(tab_i[i].b) - DiffW'(1) - DiffW'(tab_i[i].a);
      dc      = DiffW'(tab_i[i].a) + DiffW'(1) - DiffW'(tab_i[i].b);
      in_ring = {1'b0, tab_i[i].a} < ring_i;
      hit_a   = !da[DiffW-1] && (da[DiffW-2:0] <= (DiffW-1)'(MaxSites))
                && mask_i[da[MaskIdxW-1:0]];
      hit_b   = (!db[DiffW-1] && (db[DiffW-2:0] <= (DiffW-1)'(MaxSites))
                 && mask_i[db[MaskIdxW-1:0]])
                || (dc == DiffW'(ring_i));
      nb[i]   = (used_i > UsedW'(i)) && in_ring && (hit_a || hit_b);
    end
  end

  assign count_o = CntW'($countones(nb));

endmodule

// ----- design/valence_bond_reconnect.sv -----
// Top level of valence_bond_reconnect: input beat register, pair table,
// neighbour count, result register and ring_size register. Depends on vbr_pkg.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    in_data_i  (in_item_t)
//   out      output     out_valid_o / out_stall_i  out_data_o (out_item_t)
//   cfg      input      cfg_we_i                   cfg_wdata_i (ring_size)
//
// One beat per cycle unless an output stall holds the flow; each beat passes the
// input register and then the result register. The whole match, swap and count
// run combinationally over the 16 slots between the input and result registers.
// Reset clears valid flags and sets ring_size to 30; table cells are not reset.
// An output stall holds the result; the input register keeps one more beat.
module valence_bond_reconnect import vbr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [RingW-1:0] cfg_wdata_i
);

  logic             in_vld_q;
  in_item_t         in_q;
  logic             out_vld_q;
  out_item_t        out_q;
  logic [RingW-1:0] ring_q;
  logic [MaskW-1:0] mask_q;
  logic             fire, in_take;
  logic [UsedW-1:0] used;
  pair_tab_t        tab_nxt;
  logic             reconn;
  logic [CntW-1:0]  cnt;

  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;
  assign used       = ring_q[RingW-1] ? UsedW'(PairSlots) : UsedW'(ring_q[RingW-2:1]);

  vbr_table u_table (
    .clk_i         (clk_i),
    .fire_i        (fire),
    .item_i        (in_q),
    .used_i        (used),
    .tab_nxt_o     (tab_nxt),
    .reconnected_o (reconn)
  );

  vbr_nbr_count u_count (
    .tab_i   (tab_nxt),
    .used_i  (used),
    .ring_i  (ring_q),
    .mask_i  (mask_q),
    .count_o (cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      ring_q    <= RingReset;
      mask_q    <= MaskReset;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        ring_q <= cfg_wdata_i;
        mask_q <= mult_mask(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q.reconnected     <= reconn;
      out_q.neighbour_bonds <= cnt;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
